// ===== rtl/b16fadd_pkg.sv =====
// b16fadd_pkg: constants, stage payload types and helpers for the binary16 adder
// no dependencies; imported by binary16_float_adder
`timescale 1ns / 1ps

package b16fadd_pkg;

    // binary16 layout
    localparam int C_EXP_W  = 5;
    localparam int C_FRAC_W = 10;
    localparam int C_MANT_W = C_FRAC_W + 1;            // with hidden bit
    localparam int C_EXTRA  = 3;                       // guard, round, sticky
    localparam int C_ALN_W  = C_MANT_W + C_EXTRA;      // aligned mantissa
    localparam int C_SUM_W  = C_ALN_W + 1;             // with carry

    localparam logic [C_EXP_W-1:0] C_EXP_ONES = 5'h1F;
    localparam logic [15:0]        C_QNAN     = 16'h7C01;
    localparam logic [14:0]        C_MAG_INF  = 15'h7C00;

    // first stage: sorted operands and special result
    typedef struct packed {
        logic                special;
        logic [15:0]         spec_val;
        logic                sign;
        logic                same;
        logic [C_EXP_W-1:0]  exp_big;
        logic [C_MANT_W-1:0] mant_big;
        logic [C_MANT_W-1:0] mant_small;
        logic [C_EXP_W-1:0]  diff;
    } t_s1;

    // second stage: raw sum or difference
    typedef struct packed {
        logic               special;
        logic [15:0]        spec_val;
        logic               sign;
        logic               same;
        logic [C_EXP_W-1:0] exp_big;
        logic [C_SUM_W-1:0] sum;
    } t_s2;

    // third stage: normalised mantissa with guard bits
    typedef struct packed {
        logic               special;
        logic [15:0]        spec_val;
        logic               sign;
        logic               same;
        logic               zero;
        logic [C_EXP_W-1:0] exp;
        logic [C_ALN_W-1:0] mant;
    } t_s3;

    // leading zero count of a nonzero aligned mantissa
    function automatic logic [3:0] lead_zeros(input logic [C_ALN_W-1:0] v);
        logic [3:0] lz;
        lz = 4'(C_ALN_W - 1);
        for (int i = 0; i < C_ALN_W; i++) begin
            if (v[i]) begin
                lz = 4'(C_ALN_W - 1 - i);
            end
        end
        return lz;
    endfunction

endpackage

// ===== rtl/binary16_float_adder.sv =====
// binary16_float_adder: pipelined IEEE 754 half-precision adder
// depends on b16fadd_pkg for layout constants, stage types and leading zero count
// result path: an accepted request passes through r_s1, r_s2, r_s3 and r_out before result valid on the master side
// throughput: one request per cycle; a stage holds only while the one after it is full and stalled
// stages: sort/classify, align/add, normalise, round/pack into the output register
// reset: synchronous active low, clears all stage valid bits; payloads are not reset
`timescale 1ns / 1ps

module binary16_float_adder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [15:0] operand_a, [31:16] operand_b
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata    // [15:0] sum_bits
);

    import b16fadd_pkg::*;

    logic r_v1, r_v2, r_v3, r_v4;
    t_s1  r_s1, n_s1;
    t_s2  r_s2, n_s2;
    t_s3  r_s3, n_s3;
    logic [15:0] r_out, n_out;

    logic w_rdy1, w_rdy2, w_rdy3, w_rdy4;

    // stage ready chain, bubbles collapse
    assign w_rdy4        = !r_v4 || m_axis_tready;
    assign w_rdy3        = !r_v3 || w_rdy4;
    assign w_rdy2        = !r_v2 || w_rdy3;
    assign w_rdy1        = !r_v1 || w_rdy2;
    assign s_axis_tready = w_rdy1;
    assign m_axis_tvalid = r_v4;
    assign m_axis_tdata  = r_out;

    // stage 1: classify specials, order by magnitude
    logic [15:0]         w_a, w_b, w_big, w_small;
    logic                w_nan_a, w_nan_b, w_inf_a, w_inf_b;
    logic [C_EXP_W-1:0]  w_eb, w_es;

    always_comb begin
        w_a     = s_axis_tdata[15:0];
        w_b     = s_axis_tdata[31:16];
        w_nan_a = (w_a[14:10] == C_EXP_ONES) && (w_a[9:0] != '0);
        w_nan_b = (w_b[14:10] == C_EXP_ONES) && (w_b[9:0] != '0);
        w_inf_a = (w_a[14:0] == C_MAG_INF);
        w_inf_b = (w_b[14:0] == C_MAG_INF);

        n_s1.special  = w_nan_a || w_nan_b || w_inf_a || w_inf_b;
        if (w_nan_a || w_nan_b) begin
            n_s1.spec_val = C_QNAN;
        end else if (w_inf_a && w_inf_b) begin
            n_s1.spec_val = (w_a == w_b) ? w_a : C_QNAN;
        end else if (w_inf_a) begin
            n_s1.spec_val = w_a;
        end else begin
            n_s1.spec_val = w_b;
        end

        if (w_a[14:0] > w_b[14:0]) begin
            w_big   = w_a;
            w_small = w_b;
        end else begin
            w_big   = w_b;
            w_small = w_a;
        end

        // exponent field of zero means exponent one without hidden bit
        w_eb = (w_big[14:10] == '0)   ? C_EXP_W'(1) : w_big[14:10];
        w_es = (w_small[14:10] == '0) ? C_EXP_W'(1) : w_small[14:10];

        n_s1.sign       = w_big[15];
        n_s1.same       = (w_a[15] == w_b[15]);
        n_s1.exp_big    = w_eb;
        n_s1.mant_big   = {(w_big[14:10] != '0), w_big[9:0]};
        n_s1.mant_small = {(w_small[14:10] != '0), w_small[9:0]};
        n_s1.diff       = w_eb - w_es;
    end

    // stage 2: align smaller operand with sticky, then add or subtract
    logic [C_ALN_W-1:0] w_ms_ext, w_lost_mask, w_aligned;
    logic [C_SUM_W-1:0] w_mb_sum, w_al_sum;

    always_comb begin
        w_ms_ext    = {r_s1.mant_small, {C_EXTRA{1'b0}}};
        w_lost_mask = ~({C_ALN_W{1'b1}} << r_s1.diff[3:0]);
        if (r_s1.diff[4]) begin
            w_aligned = {{(C_ALN_W-1){1'b0}}, (r_s1.mant_small != '0)};
        end else begin
            w_aligned = (w_ms_ext >> r_s1.diff[3:0])
                      | {{(C_ALN_W-1){1'b0}}, ((w_ms_ext & w_lost_mask) != '0)};
        end
        w_mb_sum = {1'b0, r_s1.mant_big, {C_EXTRA{1'b0}}};
        w_al_sum = {1'b0, w_aligned};

        n_s2.special  = r_s1.special;
        n_s2.spec_val = r_s1.spec_val;
        n_s2.sign     = r_s1.sign;
        n_s2.same     = r_s1.same;
        n_s2.exp_big  = r_s1.exp_big;
        n_s2.sum      = r_s1.same ? (w_mb_sum + w_al_sum) : (w_mb_sum - w_al_sum);
    end

    // stage 3: normalise, left shift limited by the exponent
    logic [3:0]         w_lz, w_sh;
    logic [C_EXP_W-1:0] w_emax;

    always_comb begin
        w_lz   = lead_zeros(r_s2.sum[C_ALN_W-1:0]);
        w_emax = r_s2.exp_big - C_EXP_W'(1);
        w_sh   = ({1'b0, w_lz} < w_emax) ? w_lz : w_emax[3:0];

        n_s3.special  = r_s2.special;
        n_s3.spec_val = r_s2.spec_val;
        n_s3.sign     = r_s2.sign;
        n_s3.same     = r_s2.same;
        n_s3.zero     = (r_s2.sum == '0);
        if (r_s2.sum[C_SUM_W-1]) begin
            // carry out: one right shift keeping the sticky bit
            n_s3.mant = r_s2.sum[C_SUM_W-1:1] | {{(C_ALN_W-1){1'b0}}, r_s2.sum[0]};
            n_s3.exp  = r_s2.exp_big + C_EXP_W'(1);
        end else begin
            n_s3.mant = r_s2.sum[C_ALN_W-1:0] << w_sh;
            n_s3.exp  = r_s2.exp_big - C_EXP_W'(w_sh);
        end
    end

    // stage 4: round to nearest even, pack, overflow to infinity
    logic [2:0]          w_grs;
    logic [C_MANT_W-1:0] w_q, w_q2;
    logic [C_MANT_W:0]   w_q1;
    logic                w_up;
    logic [C_EXP_W:0]    w_e2;
    logic [14:0]         w_mag;

    always_comb begin
        w_grs = r_s3.mant[C_EXTRA-1:0];
        w_q   = r_s3.mant[C_ALN_W-1:C_EXTRA];
        w_up  = (w_grs > 3'd4) || ((w_grs == 3'd4) && w_q[0]);
        w_q1  = {1'b0, w_q} + {{C_MANT_W{1'b0}}, w_up};
        if (w_q1[C_MANT_W]) begin
            w_q2 = w_q1[C_MANT_W:1];
            w_e2 = {1'b0, r_s3.exp} + (C_EXP_W+1)'(1);
        end else begin
            w_q2 = w_q1[C_MANT_W-1:0];
            w_e2 = {1'b0, r_s3.exp};
        end
        w_mag = {w_e2[C_EXP_W-1:0] - C_EXP_W'(1), {C_FRAC_W{1'b0}}}
              + {4'b0, w_q2};

        if (r_s3.special) begin
            n_out = r_s3.spec_val;
        end else if (r_s3.zero) begin
            // exact cancellation gives +0, equal-signed zeros keep their sign
            n_out = r_s3.same ? {r_s3.sign, 15'b0} : 16'h0000;
        end else if (w_e2 >= (C_EXP_W+1)'(C_EXP_ONES)) begin
            n_out = {r_s3.sign, C_MAG_INF};
        end else begin
            n_out = {r_s3.sign, w_mag};
        end
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (w_rdy1) r_v1 <= s_axis_tvalid;
            if (w_rdy2) r_v2 <= r_v1;
            if (w_rdy3) r_v3 <= r_v2;
            if (w_rdy4) r_v4 <= r_v3;
        end
    end

    // stage payloads
    always_ff @(posedge i_clk) begin
        if (w_rdy1) r_s1  <= n_s1;
        if (w_rdy2) r_s2  <= n_s2;
        if (w_rdy3) r_s3  <= n_s3;
        if (w_rdy4) r_out <= n_out;
    end

endmodule
